// ===== src/hsbp_pkg.sv =====
// hsbp_pkg: shared types and constants of the huffman stream bit packer
// no dependencies; imported by every module of the block
`default_nettype none

package hsbp_pkg;

	localparam int TABLE_DEPTH = 128;
	localparam int SYM_W       = 7;
	localparam int CODE_W      = 32;
	localparam int LEN_W       = 6;
	localparam int BYTE_W      = 8;
	localparam int HDR_BITS    = 16;
	localparam int NBITS_W     = 7;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_PTR_W  = 2;

	localparam logic [2:0] FUNC_LOAD   = 3'd0;
	localparam logic [2:0] FUNC_RAW    = 3'd1;
	localparam logic [2:0] FUNC_EMIT   = 3'd2;
	localparam logic [2:0] FUNC_ENCODE = 3'd3;
	localparam logic [2:0] FUNC_FINISH = 3'd4;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_NO_CODE  = 2'd1;
	localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

	typedef enum logic [1:0] {
		JOB_PUSH,
		JOB_STATUS,
		JOB_FINISH
	} job_kind_t;

	typedef struct packed {
		job_kind_t           kind;
		logic [1:0]          status;
		logic [NBITS_W-1:0]  nbits;
	} job_ctl_t;

endpackage

`default_nettype wire

// ===== src/hsbp_front.sv =====
// hsbp_front: input stage, code table memories, entry valid bits, job builder
// depends on hsbp_pkg
`default_nettype none

module hsbp_front import hsbp_pkg::*; #(
	parameter int CODE_LEN_LIMIT = 32,
	parameter int SYM_COUNT      = 128,
	parameter int DATA_W         = 48
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         func,
	input  wire logic [SYM_W-1:0]   symbol,
	input  wire logic [CODE_W-1:0]  code_bits,
	input  wire logic [LEN_W-1:0]   code_length,
	input  wire logic [BYTE_W-1:0]  raw_byte,
	output logic                    job_valid,
	input  wire logic               job_ready,
	output job_ctl_t                job_ctl,
	output logic [DATA_W-1:0]       job_data
);

	localparam int SH_W  = $clog2(CODE_LEN_LIMIT + 1);
	localparam int EXT_W = CODE_LEN_LIMIT + CODE_W;

	logic [CODE_W-1:0] code_mem [TABLE_DEPTH];
	logic [LEN_W-1:0]  len_mem  [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] entry_valid_q;

	logic               valid_s1;
	logic [2:0]         func_s1;
	logic [SYM_W-1:0]   symbol_s1;
	logic [LEN_W-1:0]   code_length_s1;
	logic [BYTE_W-1:0]  raw_byte_s1;
	logic [CODE_W-1:0]  code_rd_s1;
	logic [LEN_W-1:0]   len_rd_s1;

	logic               accept;
	logic               load_ok;
	logic               has_job;
	logic               has_code;
	logic [SH_W-1:0]    align_sh;
	logic [EXT_W-1:0]   code_ext;
	logic [EXT_W-1:0]   code_shifted;
	logic [CODE_LEN_LIMIT-1:0] code_aligned;

	assign accept  = in_valid && in_ready;
	assign load_ok = (func == FUNC_LOAD) && (int'(code_length) <= CODE_LEN_LIMIT)
		&& (int'(symbol) < SYM_COUNT);

	// the stage moves on when its job has no word to hand over or the queue takes it
	assign in_ready  = !valid_s1 || !has_job || job_ready;
	assign job_valid = valid_s1 && has_job;

	always_ff @(posedge clk) begin
		if (accept) begin
			if (load_ok) begin
				code_mem[symbol] <= code_bits;
				len_mem[symbol]  <= code_length;
			end
			code_rd_s1     <= code_mem[symbol];
			len_rd_s1      <= len_mem[symbol];
			func_s1        <= func;
			symbol_s1      <= symbol;
			code_length_s1 <= code_length;
			raw_byte_s1    <= raw_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			entry_valid_q <= '0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (accept && load_ok) entry_valid_q[symbol] <= 1'b1;
		end
	end

	// left-align the code so its first bit lands on the top of the field
	assign has_code     = entry_valid_q[symbol_s1] && (int'(symbol_s1) < SYM_COUNT);
	assign align_sh     = SH_W'(CODE_LEN_LIMIT) - SH_W'(len_rd_s1);
	assign code_ext     = {{CODE_LEN_LIMIT{1'b0}}, code_rd_s1};
	assign code_shifted = code_ext << align_sh;
	assign code_aligned = code_shifted[CODE_LEN_LIMIT-1:0];

	always_comb begin
		has_job        = 1'b0;
		job_ctl.kind   = JOB_PUSH;
		job_ctl.status = STATUS_OK;
		job_ctl.nbits  = '0;
		job_data       = '0;
		case (func_s1)
			FUNC_LOAD: begin
				if (int'(code_length_s1) > CODE_LEN_LIMIT) begin
					has_job        = 1'b1;
					job_ctl.kind   = JOB_STATUS;
					job_ctl.status = STATUS_TOO_LONG;
				end else if (int'(symbol_s1) >= SYM_COUNT) begin
					has_job        = 1'b1;
					job_ctl.kind   = JOB_STATUS;
					job_ctl.status = STATUS_NO_CODE;
				end
			end
			FUNC_RAW: begin
				has_job       = 1'b1;
				job_ctl.nbits = NBITS_W'(BYTE_W);
				job_data      = {raw_byte_s1, {(DATA_W-BYTE_W){1'b0}}};
			end
			FUNC_EMIT, FUNC_ENCODE: begin
				has_job = 1'b1;
				if (!has_code) begin
					job_ctl.kind   = JOB_STATUS;
					job_ctl.status = STATUS_NO_CODE;
				end else if (func_s1 == FUNC_EMIT) begin
					job_ctl.nbits = NBITS_W'(len_rd_s1) + NBITS_W'(HDR_BITS);
					job_data      = {1'b0, symbol_s1, 2'b00, len_rd_s1, code_aligned};
				end else begin
					job_ctl.nbits = NBITS_W'(len_rd_s1);
					job_data      = {code_aligned, {HDR_BITS{1'b0}}};
				end
			end
			FUNC_FINISH: begin
				has_job      = 1'b1;
				job_ctl.kind = JOB_FINISH;
			end
			default: begin
				has_job = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== src/hsbp_job_fifo.sv =====
// hsbp_job_fifo: short queue of packed jobs between front and back
// depends on hsbp_pkg for its depth
`default_nettype none

module hsbp_job_fifo import hsbp_pkg::*; #(
	parameter int WIDTH = 59
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output logic [WIDTH-1:0]      pop_data
);

	logic [WIDTH-1:0]      slot_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_PTR_W:0]   count_q;
	logic                  do_push;
	logic                  do_pop;

	assign push_ready = (count_q != (FIFO_PTR_W+1)'(FIFO_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== src/hsbp_back.sv =====
// hsbp_back: bit accumulator, byte packer and output register
// depends on hsbp_pkg
`default_nettype none

module hsbp_back import hsbp_pkg::*; #(
	parameter int DATA_W = 48
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              job_valid,
	output logic                   job_ready,
	input  wire job_ctl_t          job_ctl,
	input  wire logic [DATA_W-1:0] job_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [BYTE_W-1:0]      out_byte,
	output logic                   byte_valid,
	output logic                   last,
	output logic [1:0]             status
);

	logic               act_q;
	job_kind_t          kind_q;
	logic [1:0]         jstat_q;
	logic [NBITS_W-1:0] rem_q;
	logic [DATA_W-1:0]  data_q;
	logic [6:0]         pbits_q;
	logic [2:0]         pcnt_q;

	logic               out_valid_q;
	logic [BYTE_W-1:0]  out_byte_q;
	logic               byte_valid_q;
	logic               last_q;
	logic [1:0]         status_q;

	logic [3:0]         avail;
	logic [3:0]         take;
	logic               full;
	logic [15:0]        merged;
	logic [NBITS_W-1:0] rem_next;
	logic [BYTE_W-1:0]  pad_byte;
	logic               out_free;
	logic               step;
	logic               word_out;

	assign job_ready  = !act_q;
	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign byte_valid = byte_valid_q;
	assign last       = last_q;
	assign status     = status_q;

	// bits taken this cycle: up to what completes the pending byte
	assign avail    = 4'd8 - {1'b0, pcnt_q};
	assign take     = (rem_q < NBITS_W'(avail)) ? rem_q[3:0] : avail;
	assign full     = (take == avail);
	assign merged   = {1'b0, pbits_q, data_q[DATA_W-1 -: BYTE_W]} << take;
	assign rem_next = rem_q - NBITS_W'(take);
	assign pad_byte = {1'b0, pbits_q} << avail[2:0];
	assign out_free = !out_valid_q || out_ready;
	assign step     = act_q && out_free;
	assign word_out = step && (kind_q == JOB_STATUS || kind_q == JOB_FINISH
		|| (kind_q == JOB_PUSH && full));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q        <= 1'b0;
			kind_q       <= JOB_PUSH;
			jstat_q      <= STATUS_OK;
			rem_q        <= '0;
			data_q       <= '0;
			pbits_q      <= '0;
			pcnt_q       <= '0;
			out_valid_q  <= 1'b0;
			out_byte_q   <= '0;
			byte_valid_q <= 1'b0;
			last_q       <= 1'b0;
			status_q     <= STATUS_OK;
		end else begin
			if (word_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (!act_q) begin
				if (job_valid) begin
					act_q   <= 1'b1;
					kind_q  <= job_ctl.kind;
					jstat_q <= job_ctl.status;
					rem_q   <= job_ctl.nbits;
					data_q  <= job_data;
				end
			end else if (step) begin
				case (kind_q)
					JOB_STATUS: begin
						out_byte_q   <= '0;
						byte_valid_q <= 1'b0;
						last_q       <= 1'b1;
						status_q     <= jstat_q;
						act_q        <= 1'b0;
					end
					JOB_FINISH: begin
						byte_valid_q <= 1'b1;
						status_q     <= STATUS_OK;
						if (pcnt_q != '0) begin
							// padded byte now, then the pad count as an ordinary byte
							out_byte_q <= pad_byte;
							last_q     <= 1'b0;
							pbits_q    <= '0;
							pcnt_q     <= '0;
							kind_q     <= JOB_PUSH;
							rem_q      <= NBITS_W'(BYTE_W);
							data_q     <= {5'b00000, avail[2:0], {(DATA_W-BYTE_W){1'b0}}};
						end else begin
							out_byte_q <= '0;
							last_q     <= 1'b1;
							act_q      <= 1'b0;
						end
					end
					JOB_PUSH: begin
						data_q <= data_q << take;
						rem_q  <= rem_next;
						if (rem_next == '0) act_q <= 1'b0;
						if (full) begin
							out_byte_q   <= merged[15:8];
							byte_valid_q <= 1'b1;
							last_q       <= (rem_next < NBITS_W'(BYTE_W));
							status_q     <= STATUS_OK;
							pbits_q      <= '0;
							pcnt_q       <= '0;
						end else begin
							pbits_q <= merged[14:8];
							pcnt_q  <= pcnt_q + take[2:0];
						end
					end
					default: begin
						act_q <= 1'b0;
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/huffman_stream_bit_packer.sv =====
// huffman_stream_bit_packer: top level, front stage, job queue and byte packer
// depends on hsbp_pkg, hsbp_front, hsbp_job_fifo, hsbp_back
//
//   channel | handshake             | words
//   in      | in_valid / in_ready   | func, symbol, code_bits, code_length, raw_byte
//   out     | out_valid / out_ready | out_byte, byte_valid, last, status
//
// an item that yields a job is registered in the front stage and then enters the job queue;
// the packer takes a new job only when idle, then works through it one chunk of bits at a
// time, each chunk filling the pending byte (one word) or ending the job with bits left over
// status and finish jobs: one word, but a padded byte first if a finish finds bits pending
// reset clears the entry valid bits, the accumulator, the queue and all valid flags
// a stalled output holds the packer; the queue then fills and in_ready drops
`default_nettype none

module huffman_stream_bit_packer import hsbp_pkg::*; #(
	parameter int CODE_LEN_LIMIT = 32,
	parameter int SYM_COUNT      = 128
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         func,
	input  wire logic [SYM_W-1:0]   symbol,
	input  wire logic [CODE_W-1:0]  code_bits,
	input  wire logic [LEN_W-1:0]   code_length,
	input  wire logic [BYTE_W-1:0]  raw_byte,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [BYTE_W-1:0]       out_byte,
	output logic                    byte_valid,
	output logic                    last,
	output logic [1:0]              status
);

	localparam int DATA_W = CODE_LEN_LIMIT + HDR_BITS;
	localparam int CTL_W  = $bits(job_ctl_t);
	localparam int JOB_W  = CTL_W + DATA_W;

	logic              fj_valid;
	logic              fj_ready;
	job_ctl_t          fj_ctl;
	logic [DATA_W-1:0] fj_data;
	logic              bj_valid;
	logic              bj_ready;
	logic [JOB_W-1:0]  bj_word;
	job_ctl_t          bj_ctl;
	logic [DATA_W-1:0] bj_data;

	hsbp_front #(
		.CODE_LEN_LIMIT (CODE_LEN_LIMIT),
		.SYM_COUNT      (SYM_COUNT),
		.DATA_W         (DATA_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.symbol      (symbol),
		.code_bits   (code_bits),
		.code_length (code_length),
		.raw_byte    (raw_byte),
		.job_valid   (fj_valid),
		.job_ready   (fj_ready),
		.job_ctl     (fj_ctl),
		.job_data    (fj_data)
	);

	hsbp_job_fifo #(
		.WIDTH (JOB_W)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fj_valid),
		.push_ready (fj_ready),
		.push_data  ({fj_ctl, fj_data}),
		.pop_valid  (bj_valid),
		.pop_ready  (bj_ready),
		.pop_data   (bj_word)
	);

	assign bj_ctl  = job_ctl_t'(bj_word[JOB_W-1 -: CTL_W]);
	assign bj_data = bj_word[DATA_W-1:0];

	hsbp_back #(
		.DATA_W (DATA_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (bj_valid),
		.job_ready  (bj_ready),
		.job_ctl    (bj_ctl),
		.job_data   (bj_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.last       (last),
		.status     (status)
	);

endmodule

`default_nettype wire

// ===== tb/tb_huffman_stream_bit_packer.sv =====
// tb_huffman_stream_bit_packer: self-checking bench for the huffman stream bit packer
// drives table loads, raw bytes, entry emits, encodes, finishes and spare funcs, predicts every packed word
// depends on hsbp_pkg and huffman_stream_bit_packer
module tb_huffman_stream_bit_packer import hsbp_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_LEN       = 32;
	localparam int ALPHABET      = 128;
	localparam int ITEM_TARGET   = 460;
	localparam int TAIL_ITEMS    = 50;
	localparam int SETTLE_CYCLES = 40;
	localparam int STUCK_LIMIT   = 2000;

	localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
	localparam logic [2:0] FUNC_SPARE_MID   = 3'd6;
	localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;

	typedef struct {
		logic [2:0]        func;
		logic [SYM_W-1:0]  symbol;
		logic [CODE_W-1:0] code_bits;
		logic [LEN_W-1:0]  code_length;
		logic [BYTE_W-1:0] raw_byte;
		bit                wait_drain;
	} packer_cmd_t;

	typedef struct {
		logic [BYTE_W-1:0] out_byte;
		logic              byte_valid;
		logic              last;
		logic [1:0]        status;
	} packer_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] func = '0;
	logic [SYM_W-1:0] symbol = '0;
	logic [CODE_W-1:0] code_bits = '0;
	logic [LEN_W-1:0] code_length = '0;
	logic [BYTE_W-1:0] raw_byte = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [BYTE_W-1:0] out_byte;
	logic byte_valid;
	logic last;
	logic [1:0] status;

	huffman_stream_bit_packer #(
		.CODE_LEN_LIMIT(MAX_LEN),
		.SYM_COUNT(ALPHABET)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.symbol(symbol),
		.code_bits(code_bits),
		.code_length(code_length),
		.raw_byte(raw_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.byte_valid(byte_valid),
		.last(last),
		.status(status)
	);

	always #6 clk = ~clk;

	// predictor state
	logic [CODE_W-1:0] pred_code [TABLE_DEPTH];
	logic [LEN_W-1:0]  pred_len [TABLE_DEPTH];
	bit                pred_loaded [TABLE_DEPTH];
	logic [7:0]        acc_bits;
	int                acc_count;

	packer_cmd_t  cmd_queue [$];
	packer_word_t words_due [$];
	packer_word_t step_words [$];
	packer_cmd_t  on_bus;

	// stimulus-side view of which symbols hold a code
	bit gen_known [TABLE_DEPTH];
	int known_syms [$];
	int stimulus_count;

	int error_count;
	int words_checked;
	int no_code_seen;
	int too_long_seen;
	int func_hits [8];
	int cycle_no;
	int stuck_cycles;
	int send_gap;
	int stall_left;

	function automatic bit calm_tail();
		return cmd_queue.size() < TAIL_ITEMS;
	endfunction

	function automatic void add_word(logic [7:0] b, logic v, logic [1:0] st);
		packer_word_t w;
		w.out_byte = b;
		w.byte_valid = v;
		w.last = 1'b0;
		w.status = st;
		step_words.push_back(w);
	endfunction

	// append bits msb first, closing a word whenever eight have gathered
	function automatic void shift_bits(logic [CODE_W-1:0] value, int nbits);
		for (int i = nbits - 1; i >= 0; i--) begin
			acc_bits = {acc_bits[6:0], value[i]};
			acc_count++;
			if (acc_count == 8) begin
				add_word(acc_bits, 1'b1, STATUS_OK);
				acc_bits = '0;
				acc_count = 0;
			end
		end
	endfunction

	function automatic void packer_predict(packer_cmd_t c);
		int pad;
		bit known;
		step_words.delete();
		known = int'(c.symbol) < ALPHABET && pred_loaded[c.symbol];
		case (c.func)
			FUNC_LOAD: begin
				if (int'(c.code_length) > MAX_LEN) begin
					add_word('0, 1'b0, STATUS_TOO_LONG);
				end else if (int'(c.symbol) >= ALPHABET) begin
					add_word('0, 1'b0, STATUS_NO_CODE);
				end else begin
					pred_code[c.symbol] = c.code_bits;
					pred_len[c.symbol] = c.code_length;
					pred_loaded[c.symbol] = 1'b1;
				end
			end
			FUNC_RAW: shift_bits(CODE_W'(c.raw_byte), 8);
			FUNC_EMIT: begin
				if (!known) begin
					add_word('0, 1'b0, STATUS_NO_CODE);
				end else begin
					shift_bits(CODE_W'(c.symbol), 8);
					shift_bits(CODE_W'(pred_len[c.symbol]), 8);
					shift_bits(pred_code[c.symbol], pred_len[c.symbol]);
				end
			end
			FUNC_ENCODE: begin
				if (!known)
					add_word('0, 1'b0, STATUS_NO_CODE);
				else
					shift_bits(pred_code[c.symbol], pred_len[c.symbol]);
			end
			FUNC_FINISH: begin
				pad = (acc_count != 0) ? 8 - acc_count : 0;
				shift_bits('0, pad);
				shift_bits(CODE_W'(pad), 8);
			end
			default: ;
		endcase
		if (step_words.size() != 0)
			step_words[step_words.size() - 1].last = 1'b1;
		foreach (step_words[i])
			words_due.push_back(step_words[i]);
	endfunction

	function automatic void flag_field(string name, logic [7:0] want, logic [7:0] got);
		$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
		error_count++;
	endfunction

	function automatic void add_item(logic [2:0] f, int sym, logic [CODE_W-1:0] code, int len,
			int raw, bit drain);
		packer_cmd_t c;
		c.func = f;
		c.symbol = SYM_W'(sym);
		c.code_bits = code;
		c.code_length = LEN_W'(len);
		c.raw_byte = BYTE_W'(raw);
		c.wait_drain = drain;
		cmd_queue.push_back(c);
		stimulus_count++;
	endfunction

	function automatic int pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return 0;
		if (r < 60)
			return $urandom_range(1, 8);
		if (r < 85)
			return $urandom_range(9, 20);
		if (r < 94)
			return $urandom_range(21, MAX_LEN);
		return $urandom_range(MAX_LEN + 1, 63);
	endfunction

	function automatic int pick_symbol();
		if (known_syms.size() != 0 && $urandom_range(0, 9) != 0)
			return known_syms[$urandom_range(0, known_syms.size() - 1)];
		return $urandom_range(0, 127);
	endfunction

	function automatic void load_entry(int sym, logic [CODE_W-1:0] code, int len, bit drain);
		add_item(FUNC_LOAD, sym, code, len, $urandom, drain);
		if (len <= MAX_LEN && !gen_known[sym]) begin
			gen_known[sym] = 1'b1;
			known_syms.push_back(sym);
		end
	endfunction

	// input driver
	always @(posedge clk or negedge arst_n) begin
		bit next_valid;
		if (!arst_n) begin
			in_valid <= 1'b0;
			func <= '0;
			symbol <= '0;
			code_bits <= '0;
			code_length <= '0;
			raw_byte <= '0;
			send_gap = 0;
		end else begin
			next_valid = in_valid;
			if (in_valid && in_ready) begin
				packer_predict(on_bus);
				func_hits[on_bus.func]++;
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (!calm_tail() && (cycle_no / 200) % 3 != 2
						&& $urandom_range(0, 9) == 0) begin
					send_gap = $urandom_range(0, 6);
				end else if (cmd_queue.size() != 0
						&& !(cmd_queue[0].wait_drain && words_due.size() != 0)) begin
					on_bus = cmd_queue.pop_front();
					func <= on_bus.func;
					symbol <= on_bus.symbol;
					code_bits <= on_bus.code_bits;
					code_length <= on_bus.code_length;
					raw_byte <= on_bus.raw_byte;
					next_valid = 1'b1;
				end
			end
			in_valid <= next_valid;
		end
	end

	// output monitor and ready control
	always @(posedge clk or negedge arst_n) begin
		packer_word_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (words_due.size() == 0) begin
					$display("%0t: unexpected word, expected none %s %h valid %b last %b status %0d",
						$time, "actual byte", out_byte, byte_valid, last, status);
					error_count++;
				end else begin
					want = words_due.pop_front();
					words_checked++;
					if (out_byte !== want.out_byte)
						flag_field("out_byte", want.out_byte, out_byte);
					if (byte_valid !== want.byte_valid)
						flag_field("byte_valid", 8'(want.byte_valid), 8'(byte_valid));
					if (last !== want.last)
						flag_field("last", 8'(want.last), 8'(last));
					if (status !== want.status)
						flag_field("status", 8'(want.status), 8'(status));
					if (want.status == STATUS_NO_CODE)
						no_code_seen++;
					if (want.status == STATUS_TOO_LONG)
						too_long_seen++;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!calm_tail() && (cycle_no / 170) % 3 != 1
					&& $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 6);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		cycle_no++;
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
			if (stuck_cycles == STUCK_LIMIT) begin
				$display("%0t: no handshake for %0d cycles, %0d words still due",
					$time, STUCK_LIMIT, words_due.size());
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		int nload;
		int sym;
		int len;
		bit drain;
		int r;

		acc_bits = '0;
		acc_count = 0;
		stimulus_count = 0;
		foreach (pred_loaded[i]) begin
			pred_loaded[i] = 1'b0;
			gen_known[i] = 1'b0;
		end

		// directed: unloaded symbols, empty finish, zero length, rejects, longest emit, raw bytes, spare funcs
		add_item(FUNC_ENCODE, 0, '0, 0, 0, 1'b0);
		add_item(FUNC_EMIT, 127, '0, 0, 0, 1'b0);
		add_item(FUNC_FINISH, 0, '0, 0, 0, 1'b0);
		load_entry(0, 32'hFFFF_FFFF, 0, 1'b0);
		add_item(FUNC_ENCODE, 0, '0, 0, 0, 1'b0);
		add_item(FUNC_EMIT, 0, '0, 0, 0, 1'b0);
		load_entry(127, 32'hFFFF_FFFF, MAX_LEN, 1'b0);
		add_item(FUNC_LOAD, 1, 32'hFFFF_FFFF, MAX_LEN + 1, 8'hFF, 1'b0);
		add_item(FUNC_LOAD, 1, '0, 63, 0, 1'b0);
		add_item(FUNC_ENCODE, 1, '0, 0, 0, 1'b0);
		load_entry(2, 32'h1, 1, 1'b0);
		add_item(FUNC_ENCODE, 2, '0, 0, 0, 1'b0);
		add_item(FUNC_EMIT, 127, '0, 0, 0, 1'b0);
		add_item(FUNC_RAW, 0, '0, 0, 8'h00, 1'b0);
		add_item(FUNC_RAW, 0, '0, 0, 8'hFF, 1'b0);
		load_entry(3, 32'h0, MAX_LEN, 1'b0);
		add_item(FUNC_ENCODE, 3, '0, 0, 0, 1'b0);
		load_entry(64, 32'h2A, 7, 1'b0);
		add_item(FUNC_ENCODE, 64, '0, 0, 0, 1'b0);
		add_item(FUNC_FINISH, 0, '0, 0, 0, 1'b0);
		add_item(FUNC_SPARE_FIRST, 127, 32'hFFFF_FFFF, 63, 8'hFF, 1'b0);
		add_item(FUNC_SPARE_MID, 85, 32'h5555_5555, 21, 8'h55, 1'b0);
		add_item(FUNC_SPARE_LAST, 42, 32'hAAAA_AAAA, 42, 8'hAA, 1'b0);
		// overwrite an entry only after everything before it has drained
		load_entry(2, 32'h5, 3, 1'b1);
		add_item(FUNC_ENCODE, 2, '0, 0, 0, 1'b0);
		add_item(FUNC_FINISH, 0, '0, 0, 0, 1'b0);

		// random streams: table loads, header bytes, entry emits, symbol data, spare funcs, finish
		while (stimulus_count < ITEM_TARGET) begin
			drain = ($urandom_range(0, 5) == 0);
			nload = $urandom_range(1, 8);
			for (int i = 0; i < nload; i++) begin
				sym = $urandom_range(0, 127);
				len = pick_length();
				load_entry(sym, $urandom, len, drain && i == 0);
			end
			repeat ($urandom_range(0, 2))
				add_item(FUNC_RAW, $urandom, $urandom, $urandom, $urandom, 1'b0);
			repeat ($urandom_range(0, 3))
				add_item(FUNC_EMIT, pick_symbol(), $urandom, $urandom, $urandom, 1'b0);
			repeat ($urandom_range(4, 30)) begin
				r = $urandom_range(0, 19);
				if (r == 0)
					add_item(3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST)), $urandom,
						$urandom, $urandom, $urandom, 1'b0);
				else if (r == 1)
					add_item(FUNC_RAW, $urandom, $urandom, $urandom, $urandom, 1'b0);
				else
					add_item(FUNC_ENCODE, pick_symbol(), $urandom, $urandom, $urandom, 1'b0);
			end
			if ($urandom_range(0, 4) != 0)
				add_item(FUNC_FINISH, $urandom, $urandom, $urandom, $urandom, 1'b0);
		end
		add_item(FUNC_FINISH, 0, '0, 0, 0, 1'b0);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (cmd_queue.size() != 0 || in_valid || words_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("driven: %0d loads, %0d raw, %0d emits, %0d encodes, %0d finishes, %0d spare",
			func_hits[FUNC_LOAD], func_hits[FUNC_RAW], func_hits[FUNC_EMIT],
			func_hits[FUNC_ENCODE], func_hits[FUNC_FINISH],
			func_hits[FUNC_SPARE_FIRST] + func_hits[FUNC_SPARE_MID]
			+ func_hits[FUNC_SPARE_LAST]);
		$display("checked %0d output words, %0d no-code and %0d too-long status words",
			words_checked, no_code_seen, too_long_seen);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
src/hsbp_pkg.sv
src/hsbp_front.sv
src/hsbp_job_fifo.sv
src/hsbp_back.sv
src/huffman_stream_bit_packer.sv
tb/tb_huffman_stream_bit_packer.sv
